// ===== hw/rtl/b2h_pkg.sv =====
// shared types, constants and helpers for the keyed blake2b stream hash
`timescale 1ns / 1ps
`default_nettype none
package b2h_pkg;

  localparam int BLOCK_BYTES = 128;
  localparam int ROUNDS      = 12;
  localparam int STEPS       = ROUNDS * 16;   // two half mixes per g, eight g per round

  localparam logic [31:0] PARAM_BASE = 32'h0101_0000;
  localparam logic [5:0]  MAX_DIGEST = 6'd32;
  localparam logic [6:0]  MAX_KEY    = 7'd64;

  localparam logic [1:0] OP_ABSORB = 2'd0;
  localparam logic [1:0] OP_ABS_FIN = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] REG_DIGEST_LEN = 2'd0;
  localparam logic [1:0] REG_KEY_LEN    = 2'd1;

  localparam logic [63:0] IV [8] = '{
    64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B,
    64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
    64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
    64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
  };

  localparam logic [3:0] SIGMA [10][16] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
      4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
    '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
      4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
    '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
      4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
    '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
      4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
    '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
      4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
    '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
      4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
    '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
      4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
    '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
      4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
    '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
      4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
  };

  // controller to datapath
  typedef struct packed {
    logic       accept;
    logic       wr_byte;
    logic       cnt_add;
    logic       load;
    logic       step;
    logic       fold;
    logic       final_blk;
    logic       emit_adv;
    logic       init;
    logic [7:0] fetch_idx;
    logic [3:0] exec_stp;
  } b2h_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       key_phase;
    logic       buf_full;
    logic [1:0] op;
    logic       last_k;
  } b2h_stat_t;

  function automatic logic [3:0] b2h_sigma(input logic [3:0] rnd, input logic [3:0] stp);
    logic [3:0] row;
    row = (rnd >= 4'd10) ? rnd - 4'd10 : rnd;
    return SIGMA[row][stp];
  endfunction

  function automatic logic [5:0] b2h_clamp_dig(input logic [5:0] d);
    if (d == 6'd0) return 6'd1;
    else if (d > MAX_DIGEST) return MAX_DIGEST;
    else return d;
  endfunction

  function automatic logic [6:0] b2h_clamp_key(input logic [6:0] k);
    return (k > MAX_KEY) ? MAX_KEY : k;
  endfunction

  function automatic logic [63:0] b2h_word0(input logic [5:0] d, input logic [6:0] k);
    logic [31:0] p;
    p = PARAM_BASE ^ {17'd0, k, 8'd0} ^ {26'd0, d};
    return IV[0] ^ {32'd0, p};
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/blake2b_stream_hash.sv =====
// top level of the keyed blake2b byte stream hash
// absorb: each byte beat is accepted, then written to the buffer before the next beat is taken
// a byte that meets a full buffer first waits for a compression
//   (counter add, state load, 192 half-mix steps of one shared g unit, fold)
// finish: a final compression, then one digest beat per cycle while out_ready is high
// reset: synchronous active low, lengths 32 and 0, chain at iv with the parameter word in word 0, no buffer sweep
`timescale 1ns / 1ps
`default_nettype none
module blake2b_stream_hash import b2h_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_opcode,
  input  wire logic [7:0] in_data_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_digest_byte,
  output logic            out_last_byte,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [6:0] cfg_data
);

  // command and status between sequencer and datapath
  b2h_cmd_t  cmd;
  b2h_stat_t stat;

  // sequencer: takes one input beat at a time, steps the rounds,
  // and holds the output channel while the digest drains
  b2h_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: 16 x 64 buffer with one registered read port feeding the
  // mixer; bytes past the written limit read as zero so no clearing is needed
  b2h_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_opcode       (in_opcode),
    .in_data_byte    (in_data_byte),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cmd             (cmd),
    .stat            (stat),
    .out_digest_byte (out_digest_byte),
    .out_last_byte   (out_last_byte)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/b2h_ctrl.sv =====
// sequencer for absorb, compression rounds and digest readout
`timescale 1ns / 1ps
`default_nettype none
module b2h_ctrl import b2h_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic [1:0] in_opcode,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire b2h_stat_t stat,
  output b2h_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WRITE = 3'd1;
  localparam logic [2:0] S_CNT   = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_RUN   = 3'd4;
  localparam logic [2:0] S_FOLD  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  localparam logic [7:0] LAST_STEP = 8'(STEPS - 1);

  logic [2:0] state_r, state_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic       final_r, final_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_EMIT);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    final_nxt = final_r;
    cmd       = '0;
    cmd.final_blk = final_r;
    cmd.exec_stp  = cnt_r[3:0];
    cmd.fetch_idx = cnt_r + 8'd1;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (in_opcode)
            OP_FINISH: begin
              final_nxt = 1'b1;
              state_nxt = S_CNT;
            end
            OP_NONE: state_nxt = S_IDLE;
            default: begin
              if (!stat.key_phase && stat.buf_full) begin
                final_nxt = 1'b0;
                state_nxt = S_CNT;
              end else begin
                state_nxt = S_WRITE;
              end
            end
          endcase
        end
      end
      S_WRITE: begin
        cmd.wr_byte = 1'b1;
        if (stat.op == OP_ABS_FIN) begin
          final_nxt = 1'b1;
          state_nxt = S_CNT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_CNT: begin
        cmd.cnt_add = 1'b1;
        state_nxt   = S_LOAD;
      end
      S_LOAD: begin
        // first message word is fetched here
        cmd.load      = 1'b1;
        cmd.fetch_idx = 8'd0;
        cnt_nxt       = 8'd0;
        state_nxt     = S_RUN;
      end
      S_RUN: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 8'd1;
        if (cnt_r == LAST_STEP) state_nxt = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold  = 1'b1;
        state_nxt = final_r ? S_EMIT : S_WRITE;
      end
      S_EMIT: begin
        if (out_ready) begin
          cmd.emit_adv = 1'b1;
          if (stat.last_k) begin
            cmd.init  = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= 8'd0;
      final_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      final_r <= final_nxt;
    end
  end

  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (cnt_r <= LAST_STEP))
    else $error("round counter past last step");
  a_emit_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> final_r)
    else $error("digest readout without final block");
  a_fold_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FOLD) |-> ($past(state_r) == S_RUN))
    else $error("fold not preceded by rounds");

endmodule
`default_nettype wire

// ===== hw/rtl/b2h_dpath.sv =====
// chain words, counters, block buffer, mixing unit and digest select
`timescale 1ns / 1ps
`default_nettype none
module b2h_dpath import b2h_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [1:0] in_opcode,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [6:0] cfg_data,
  input  wire b2h_cmd_t   cmd,
  output b2h_stat_t       stat,
  output logic [7:0]      out_digest_byte,
  output logic            out_last_byte
);

  logic [5:0]  dig_reg_r, dig_reg_nxt;
  logic [6:0]  key_reg_r, key_reg_nxt;
  logic [5:0]  act_dig_r;
  logic [6:0]  act_key_r;
  logic [63:0] chain_r [8];
  logic [63:0] v_r [16];
  logic [63:0] cnt_lo_r, cnt_hi_r;
  logic [7:0]  fill_r, lim_r;
  logic [6:0]  kbs_r;
  logic        started_r;
  logic [4:0]  k_r;
  logic [1:0]  op_r;
  logic [7:0]  byte_r;

  logic [63:0] mem [16];
  logic [63:0] rdata_r;
  logic [3:0]  raddr_r;

  logic        key_phase;
  logic        do_init;
  logic [5:0]  init_dig;
  logic [6:0]  init_key;
  logic [6:0]  wpos;
  logic [7:0]  n_add;
  logic [64:0] lo_sum;
  logic [3:0]  raddr;
  logic [63:0] msg_x;
  logic [2:0]  g;
  logic [3:0]  ia, ib, ic, id;
  logic [63:0] a1, d1, c1, b1, dx, bx;

  assign key_phase = (kbs_r < act_key_r);

  always_comb begin
    dig_reg_nxt = dig_reg_r;
    key_reg_nxt = key_reg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_DIGEST_LEN: dig_reg_nxt = cfg_data[5:0];
        REG_KEY_LEN:    key_reg_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  // a write while nothing is absorbed restarts the message with new lengths
  assign do_init  = cmd.init || (cfg_we && !started_r);
  assign init_dig = b2h_clamp_dig(dig_reg_nxt);
  assign init_key = b2h_clamp_key(key_reg_nxt);

  assign wpos   = key_phase ? kbs_r : fill_r[6:0];
  assign n_add  = (cmd.final_blk && !key_phase) ? fill_r : 8'(BLOCK_BYTES);
  assign lo_sum = {1'b0, cnt_lo_r} + {57'd0, n_add};

  assign raddr = b2h_sigma(cmd.fetch_idx[7:4], cmd.fetch_idx[3:0]);

  // bytes past the written limit read as zero padding
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      msg_x[b*8 +: 8] = ({1'b0, raddr_r, 3'(b)} < lim_r) ? rdata_r[b*8 +: 8] : 8'h00;
    end
  end

  // column mixes for g 0..3, diagonals for g 4..7
  always_comb begin
    g  = cmd.exec_stp[3:1];
    ia = {2'b00, g[1:0]};
    ib = {2'b01, g[1:0] + {1'b0, g[2]}};
    ic = {2'b10, g[1:0] + {g[2], 1'b0}};
    id = {2'b11, g[1:0] + {g[2], g[2]}};
    a1 = v_r[ia] + v_r[ib] + msg_x;
    dx = v_r[id] ^ a1;
    d1 = cmd.exec_stp[0] ? {dx[15:0], dx[63:16]} : {dx[31:0], dx[63:32]};
    c1 = v_r[ic] + d1;
    bx = v_r[ib] ^ c1;
    b1 = cmd.exec_stp[0] ? {bx[62:0], bx[63]} : {bx[23:0], bx[63:24]};
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_byte) mem[wpos[6:3]][wpos[2:0]*8 +: 8] <= byte_r;
    rdata_r <= mem[raddr];
    raddr_r <= raddr;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 8; i++) v_r[i] <= chain_r[i];
      for (int i = 0; i < 4; i++) v_r[i + 8] <= IV[i];
      v_r[12] <= IV[4] ^ cnt_lo_r;
      v_r[13] <= IV[5] ^ cnt_hi_r;
      v_r[14] <= cmd.final_blk ? ~IV[6] : IV[6];
      v_r[15] <= IV[7];
    end else if (cmd.step) begin
      v_r[ia] <= a1;
      v_r[ib] <= b1;
      v_r[ic] <= c1;
      v_r[id] <= d1;
    end
    if (cmd.accept) begin
      op_r   <= in_opcode;
      byte_r <= in_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dig_reg_r <= MAX_DIGEST;
      key_reg_r <= 7'd0;
      act_dig_r <= MAX_DIGEST;
      act_key_r <= 7'd0;
      chain_r[0] <= b2h_word0(MAX_DIGEST, 7'd0);
      for (int i = 1; i < 8; i++) chain_r[i] <= IV[i];
      cnt_lo_r  <= 64'd0;
      cnt_hi_r  <= 64'd0;
      fill_r    <= 8'd0;
      lim_r     <= 8'd0;
      kbs_r     <= 7'd0;
      started_r <= 1'b0;
      k_r       <= 5'd0;
    end else begin
      dig_reg_r <= dig_reg_nxt;
      key_reg_r <= key_reg_nxt;
      if (do_init) begin
        act_dig_r <= init_dig;
        act_key_r <= init_key;
        chain_r[0] <= b2h_word0(init_dig, init_key);
        for (int i = 1; i < 8; i++) chain_r[i] <= IV[i];
        cnt_lo_r  <= 64'd0;
        cnt_hi_r  <= 64'd0;
        fill_r    <= 8'd0;
        lim_r     <= 8'd0;
        kbs_r     <= 7'd0;
        started_r <= 1'b0;
        k_r       <= 5'd0;
      end else begin
        if (cmd.wr_byte) begin
          started_r <= 1'b1;
          if (key_phase) begin
            kbs_r <= kbs_r + 7'd1;
            lim_r <= {1'b0, kbs_r} + 8'd1;
            // a complete key block counts as full
            fill_r <= (kbs_r + 7'd1 == act_key_r) ? 8'(BLOCK_BYTES)
                                                  : {1'b0, kbs_r} + 8'd1;
          end else begin
            fill_r <= fill_r + 8'd1;
            lim_r  <= fill_r + 8'd1;
          end
        end
        if (cmd.cnt_add) begin
          cnt_lo_r <= lo_sum[63:0];
          if (lo_sum[64]) cnt_hi_r <= cnt_hi_r + 64'd1;
        end
        if (cmd.fold) begin
          for (int i = 0; i < 8; i++) chain_r[i] <= chain_r[i] ^ v_r[i] ^ v_r[i + 8];
          if (!cmd.final_blk) begin
            fill_r <= 8'd0;
            lim_r  <= 8'd0;
          end
        end
        if (cmd.emit_adv) k_r <= k_r + 5'd1;
      end
    end
  end

  assign out_digest_byte = chain_r[{1'b0, ~k_r[4:3]}][(~k_r[2:0])*8 +: 8];
  assign out_last_byte   = ({1'b0, k_r} + 6'd1 == act_dig_r);

  assign stat.key_phase = key_phase;
  assign stat.buf_full  = fill_r[7];
  assign stat.op        = op_r;
  assign stat.last_k    = out_last_byte;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= 8'(BLOCK_BYTES))
    else $error("fill count past block size");
  a_lim_fill: assert property (@(posedge clk) disable iff (!rst_n)
    lim_r <= fill_r)
    else $error("written limit above fill count");
  a_key_bound: assert property (@(posedge clk) disable iff (!rst_n)
    kbs_r <= act_key_r)
    else $error("key bytes past key length");
  a_dig_range: assert property (@(posedge clk) disable iff (!rst_n)
    (act_dig_r != 6'd0) && (act_dig_r <= MAX_DIGEST))
    else $error("digest length out of range");

endmodule
`default_nettype wire
